// ===== design/beq_pkg.sv =====
// ----------------------------------------------------------------------------
// beq_pkg: shared types and constants for the byte escape quoter
// Item classes, queue entry layout and the escape tables.
// ----------------------------------------------------------------------------
package beq_pkg;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_CTL   = 2'd1,
        KIND_ESC   = 2'd2,
        KIND_HEX   = 2'd3
    } beq_kind_t;

    typedef struct packed {
        beq_kind_t   kind;
        logic [7:0]  data;
        logic        last;
        logic        err;
    } beq_entry_t;

    localparam logic       REG_DELIM_LOW  = 1'b0;
    localparam logic       REG_DELIM_HIGH = 1'b1;
    localparam logic [7:0] CHR_BSLASH     = 8'h5c;
    localparam logic [7:0] CHR_ZERO       = 8'h30;
    localparam logic [7:0] CHR_X          = 8'h78;
    localparam logic [7:0] CHR_A          = 8'h61;

    function automatic logic is_plain(input int unsigned c);
        logic p;
        p = (c >= 32) && (c <= 126);
        if (c >= 48 && c <= 57) p = 1'b0;
        if (c >= 97 && c <= 102) p = 1'b0;
        if (c == 110 || c == 114 || c == 116 || c == 118 || c == 120 || c == 92) p = 1'b0;
        return p;
    endfunction

    function automatic logic [127:0] plain_map();
        logic [127:0] m;
        m = '0;
        for (int i = 0; i < 128; i++) begin
            m[i] = is_plain(i);
        end
        return m;
    endfunction

    localparam logic [127:0] PLAIN_MAP = plain_map();

    function automatic logic [7:0] ctl_letter(input logic [2:0] i);
        logic [7:0] r;
        case (i)
            3'd0:    r = 8'h61; // a
            3'd1:    r = 8'h62; // b
            3'd2:    r = 8'h74; // t
            3'd3:    r = 8'h6e; // n
            3'd4:    r = 8'h76; // v
            3'd5:    r = 8'h66; // f
            3'd6:    r = 8'h72; // r
            default: r = 8'h61;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) r = CHR_ZERO + {4'd0, v};
        else           r = CHR_A + {4'd0, v} - 8'd10;
        return r;
    endfunction

    function automatic logic [2:0] seq_len(input beq_kind_t k);
        logic [2:0] n;
        case (k)
            KIND_PLAIN: n = 3'd1;
            KIND_CTL:   n = 3'd2;
            KIND_ESC:   n = 3'd2;
            KIND_HEX:   n = 3'd5;
            default:    n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] seq_byte(input beq_kind_t k, input logic [7:0] c,
                                            input logic [2:0] idx);
        logic [7:0] r;
        logic [3:0] off;
        off = c[3:0] - 4'd7;
        r = CHR_BSLASH;
        case (k)
            KIND_PLAIN: r = c;
            KIND_CTL:   r = (idx == 3'd0) ? CHR_BSLASH : ctl_letter(off[2:0]);
            KIND_ESC:   r = (idx == 3'd0) ? CHR_BSLASH : c;
            KIND_HEX: begin
                case (idx)
                    3'd0:    r = CHR_BSLASH;
                    3'd1:    r = CHR_ZERO;
                    3'd2:    r = CHR_X;
                    3'd3:    r = hex_digit(c[7:4]);
                    default: r = hex_digit(c[3:0]);
                endcase
            end
            default:    r = c;
        endcase
        return r;
    endfunction

endpackage

// ===== design/beq_front.sv =====
// ----------------------------------------------------------------------------
// beq_front: delimiter registers and input classification
// Holds the delimiter masks and sorts each incoming byte into an escape class.
// ----------------------------------------------------------------------------
module beq_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_addr,
    input  logic [63:0]         cfg_wdata,
    input  logic [7:0]          in_byte,
    input  logic                in_end,
    output beq_pkg::beq_entry_t entry
);
    import beq_pkg::*;

    logic [63:0]  mask_low_reg;
    logic [63:0]  mask_high_reg;
    logic [127:0] mask;
    logic         err;
    logic         is_delim;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_low_reg  <= '0;
            mask_high_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_DELIM_LOW)  mask_low_reg  <= cfg_wdata;
            if (cfg_addr == REG_DELIM_HIGH) mask_high_reg <= cfg_wdata;
        end
    end

    always_comb begin
        mask     = {mask_high_reg, mask_low_reg};
        err      = |(mask & ~PLAIN_MAP);
        is_delim = !in_byte[7] && PLAIN_MAP[in_byte[6:0]] && mask[in_byte[6:0]];
        entry.data = in_byte;
        entry.last = in_end;
        entry.err  = err;
        if (in_byte >= 8'd7 && in_byte <= 8'd13)
            entry.kind = KIND_CTL;
        else if (in_byte == CHR_BSLASH || is_delim)
            entry.kind = KIND_ESC;
        else if (in_byte < 8'd32 || in_byte >= 8'd127)
            entry.kind = KIND_HEX;
        else
            entry.kind = KIND_PLAIN;
    end

endmodule

// ===== design/beq_fifo.sv =====
// ----------------------------------------------------------------------------
// beq_fifo: classified item queue
// Short register queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module beq_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  beq_pkg::beq_entry_t push_entry,
    output logic                not_full,
    input  logic                pop,
    output beq_pkg::beq_entry_t head,
    output logic                not_empty
);
    import beq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    beq_entry_t      mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign not_full  = (count_reg != CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== design/beq_back.sv =====
// ----------------------------------------------------------------------------
// beq_back: escape sequence emitter
// Walks the current item's escape sequence into the output register, one
// byte per cycle while the output register is empty or m_tready is high.
// ----------------------------------------------------------------------------
module beq_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  beq_pkg::beq_entry_t head,
    input  logic                head_valid,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic [1:0]          m_tuser
);
    import beq_pkg::*;

    beq_entry_t  cur_reg;
    logic        cur_valid_reg;
    logic [2:0]  idx_reg;
    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    logic        out_last_reg;
    logic        out_done_reg;
    logic        out_err_reg;

    logic        cur_final;
    logic        load_out;
    logic        advance;

    always_comb begin
        cur_final = (idx_reg == seq_len(cur_reg.kind) - 3'd1);
        load_out  = !out_valid_reg || m_tready;
        advance   = cur_valid_reg && load_out;
        pop       = head_valid && (!cur_valid_reg || (advance && cur_final));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance)       out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;

            if (pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (advance && cur_final) begin
                cur_valid_reg <= 1'b0;
            end else if (advance) begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) cur_reg <= head;
        if (advance) begin
            out_data_reg <= seq_byte(cur_reg.kind, cur_reg.data, idx_reg);
            out_last_reg <= cur_final;
            out_done_reg <= cur_final && cur_reg.last;
            out_err_reg  <= cur_reg.err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_err_reg, out_done_reg};

endmodule

// ===== design/byte_escape_quoter.sv =====
// Path: an input byte passes the item queue, current-item and output registers.
// Throughput: one output byte per cycle while m_tready is high; an input byte
// yields 1, 2 or 5 bytes (plain, two-byte escape, hex escape) from the sequencer.
// The input queue keeps accepting while not full, also while the sequencer works or is stalled.
// Reset (aresetn low, synchronous): clears delimiter masks, queue and output.
// ----------------------------------------------------------------------------
// byte_escape_quoter: backslash escape encoder, top level
// Classifier, item queue and sequence emitter on stream interfaces.
// ----------------------------------------------------------------------------
module byte_escape_quoter #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [63:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // string_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // run_last
    output logic [1:0]  m_tuser    // [0] string_done, [1] delim_error
);
    import beq_pkg::*;

    beq_entry_t in_entry;
    beq_entry_t head;
    logic       not_full;
    logic       not_empty;
    logic       pop;
    logic       push;

    assign s_tready = not_full;
    assign push     = s_tvalid && not_full;

    beq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .entry     (in_entry)
    );

    beq_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (in_entry),
        .not_full   (not_full),
        .pop        (pop),
        .head       (head),
        .not_empty  (not_empty)
    );

    beq_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (not_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("string_done without run_last");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside an escape sequence");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule
